FILE: design/mlp_pattern_evaluator_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef MLP_PATTERN_EVALUATOR_DEFINES_SVH
`define MLP_PATTERN_EVALUATOR_DEFINES_SVH
// Concurrent assertion clocked on clock, disabled in reset.
`define MPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Same check, also active during reset.
`define MPE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

FILE: design/mpe_pkg.sv
// Shared types, constants and helpers for the pattern evaluator.
// No dependencies.
package mpe_pkg;
   localparam int HiddenWidth = 32;
   localparam int MaxDigits   = 10;
   localparam int WeightDepth = 4096;
   localparam int LeakNum     = 655;
   localparam int ScoreScale  = 6400;
   localparam logic [3:0] LenReset = 4'd8;
   localparam logic CmdLoad = 1'b0;
   localparam logic CmdEval = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIGIT, ST_BIAS, ST_RD, ST_MAC, ST_ACT, ST_OUT_MUL, ST_OUT_RND, ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } mac_ctl_type;

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sh7fff;
      if (v < -48'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage

FILE: design/mpe_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module mpe_ram #(
   parameter int Width = 16,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: design/mpe_digit_cell.sv
// One cell of the digit chain: holds one ternary digit, shifts it to its neighbor.
// Depends on nothing.
module mpe_digit_cell (
   input  logic       clock,
   input  logic       load,
   input  logic       shift,
   input  logic [1:0] load_digit,
   input  logic [1:0] shift_in,
   output logic [1:0] digit
);
   logic [1:0] digit_ff;
   always_ff @(posedge clock) begin
      if (load) begin
         digit_ff <= load_digit;
      end else if (shift) begin
         digit_ff <= shift_in;
      end
   end
   assign digit = digit_ff;
endmodule

FILE: design/mpe_mac.sv
// Shared multiply-accumulate unit: registered product, then 48-bit accumulate.
// Depends on mpe_pkg.
module mpe_mac (
   input  logic                       clock,
   input  mpe_pkg::mac_ctl_type       ctl,
   input  logic signed [47:0]         init,
   input  logic signed [15:0]         a,
   input  logic signed [15:0]         b,
   input  logic                       prod_valid,
   output logic signed [47:0]         acc
);
   logic signed [31:0] prod_ff;
   logic               pv_ff;
   logic signed [47:0] acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
      pv_ff   <= prod_valid & ctl.enable;
      if (ctl.clear) begin
         acc_ff <= init;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + 48'(prod_ff);
      end
   end
   assign acc = acc_ff;
endmodule

FILE: design/mlp_pattern_evaluator.sv
// Pattern evaluator: one Q3.12 MLP evaluation per evaluate transfer.
// Load transfer: no response. Evaluate: one response after digit extraction, a bias-plus-MAC
// pass per unit of layers 0, 1 and 2, the output bias, then output scaling and rounding;
// one shared MAC paced by the single weight RAM read port.
// One item in flight at a time; a pending response blocks the next transfer.
// Synchronous reset clears control and sets pattern_length to 8; weights undefined.
module mlp_pattern_evaluator #(
   parameter int HIDDEN_WIDTH = mpe_pkg::HiddenWidth,
   parameter int MAX_DIGITS   = mpe_pkg::MaxDigits,
   parameter int WEIGHT_DEPTH = mpe_pkg::WeightDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [11:0]        req_weight_addr,
   input  logic signed [15:0] req_weight_value,
   input  logic [15:0]        req_pattern_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_score,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_pattern_length
);
   localparam int AW    = $clog2(WEIGHT_DEPTH);
   localparam int HW    = (HIDDEN_WIDTH > 1) ? $clog2(HIDDEN_WIDTH) : 1;
   localparam int HA    = $clog2(2 * HIDDEN_WIDTH);
   localparam int Row0  = 2 * MAX_DIGITS;
   localparam int OffB0 = HIDDEN_WIDTH * Row0;
   localparam int OffD1 = OffB0 + HIDDEN_WIDTH;
   localparam int OffB1 = OffD1 + HIDDEN_WIDTH * HIDDEN_WIDTH;
   localparam int OffD2 = OffB1 + HIDDEN_WIDTH;
   localparam int OffB2 = OffD2 + HIDDEN_WIDTH * HIDDEN_WIDTH;
   localparam int OffD3 = OffB2 + HIDDEN_WIDTH;
   localparam int OffB3 = OffD3 + HIDDEN_WIDTH;
   localparam int JW    = $clog2(HIDDEN_WIDTH + MAX_DIGITS + 1);

   mpe_pkg::state_type state_ff, state_in;
   logic [3:0]  len_ff;
   logic [3:0]  len_eff;
   logic [1:0]  layer_ff, layer_in;
   logic [HW-1:0] unit_ff, unit_in;
   logic [JW-1:0] j_ff, j_in;
   logic [3:0]  dcnt_ff, dcnt_in;
   logic [15:0] code_ff, code_in;
   logic signed [47:0] res_ff, res_in;
   logic signed [15:0] act_ff, act_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] score_ff, score_in;
   logic signed [63:0] mul_ff, mul_in;

   assign len_eff = (len_ff > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : len_ff;

   // digit chain
   logic [1:0] dig [MAX_DIGITS];
   logic [1:0] new_digit;
   logic       d_load, d_shift;
   logic [15:0] code_div;
   logic [32:0] code_prod;
   // x / 3 as (x * 43691) >> 17, exact for 16-bit x
   assign code_prod = code_ff * 17'd43691;
   assign code_div  = code_prod[32:17];
   assign new_digit = 2'(code_ff - code_div * 16'd3);

   genvar g;
   generate
      for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
         logic [1:0] sin;
         if (g == MAX_DIGITS - 1) begin : g_last
            assign sin = d_load ? new_digit : dig[0];
         end else begin : g_mid
            assign sin = dig[g+1];
         end
         mpe_digit_cell u_cell (
            .clock(clock), .load(1'b0), .shift(d_shift),
            .load_digit(2'd0), .shift_in(sin), .digit(dig[g]));
      end
   endgenerate
   // digits enter at the top and rotate down; dig[0] is the current digit

   // weight ram
   logic          w_we;
   logic [AW-1:0] w_waddr, w_raddr;
   logic [15:0]   w_rdata;
   logic [AW:0]   raddr_full;
   mpe_ram #(.Width(16), .Depth(WEIGHT_DEPTH)) u_wram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(req_weight_value),
      .rd_addr(w_raddr), .rd_data(w_rdata));
   assign w_waddr = AW'(req_weight_addr);
   assign w_we = req_valid && req_ready && (req_cmd == mpe_pkg::CmdLoad) &&
                 ({2'b00, req_weight_addr} < 14'(WEIGHT_DEPTH));

   // hidden ram
   logic          h_we;
   logic [HA-1:0] h_waddr, h_raddr;
   logic [31:0]   h_wdata, h_rdata;
   mpe_ram #(.Width(32), .Depth(2 * HIDDEN_WIDTH)) u_hram (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata));

   // MAC
   mpe_pkg::mac_ctl_type mac_ctl;
   logic signed [47:0] mac_init, acc;
   logic signed [15:0] mac_a;
   logic               rd_pend_ff, rd_pend_in;
   logic               d_sel_ff, d_sel_in;
   mpe_mac u_mac (.clock(clock), .ctl(mac_ctl), .init(mac_init), .a(mac_a),
      .b(signed'(w_rdata)), .prod_valid(rd_pend_ff), .acc(acc));
   assign mac_a = (layer_ff == 2'd0) ? (d_sel_ff ? 16'sd4096 : 16'sd0)
                                     : signed'(h_rdata[15:0]);

   // activation
   logic signed [47:0] act_v;
   logic signed [47:0] neg_prod;
   always_comb begin
      neg_prod = acc * 48'sd655;
      if (layer_ff == 2'd0) begin
         act_v = (acc >= 0) ? (acc + 48'sd2048) >>> 12
                            : (neg_prod + (48'sd1 <<< 27)) >>> 28;
      end else begin
         act_v = (acc >= 0) ? (acc + 48'sd2048) >>> 12
                            : (neg_prod + (48'sd1 <<< 27)) >>> 28;
      end
   end
   // layer 0 accumulates with operand 4096, so it is also Q24

   logic signed [15:0] act16;
   assign act16 = mpe_pkg::sat16(act_v);

   logic [JW-1:0] jmax;
   assign jmax = (layer_ff == 2'd0) ? JW'(len_eff) : JW'(HIDDEN_WIDTH);

   logic signed [63:0] mag;
   always_comb begin
      state_in = state_ff; layer_in = layer_ff; unit_in = unit_ff; j_in = j_ff;
      dcnt_in = dcnt_ff; code_in = code_ff; res_in = res_ff; act_in = act_ff;
      rsp_valid_in = rsp_valid_ff; score_in = score_ff; mul_in = mul_ff;
      rd_pend_in = 1'b0; d_sel_in = 1'b0;
      d_load = 1'b0; d_shift = 1'b0;
      mac_ctl = '{clear: 1'b0, enable: 1'b1}; mac_init = '0;
      raddr_full = '0; h_raddr = '0; h_we = 1'b0; h_waddr = '0; h_wdata = '0;
      req_ready = 1'b0; mag = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         mpe_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready && req_cmd == mpe_pkg::CmdEval) begin
               code_in = req_pattern_code; dcnt_in = '0; state_in = mpe_pkg::ST_DIGIT;
               layer_in = 2'd0; unit_in = '0; res_in = '0;
            end
         end
         mpe_pkg::ST_DIGIT: begin
            d_load = 1'b1; d_shift = 1'b1; code_in = code_div;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(MAX_DIGITS - 1)) begin
               // rotate so digit 0 sits in cell 0
               state_in = mpe_pkg::ST_BIAS;
            end
         end
         mpe_pkg::ST_BIAS: begin
            // read bias of current unit; for layer 3 start read of bias3
            case (layer_ff)
               2'd0: raddr_full = (AW+1)'(OffB0) + (AW+1)'(unit_ff);
               2'd1: raddr_full = (AW+1)'(OffB1) + (AW+1)'(unit_ff);
               2'd2: raddr_full = (AW+1)'(OffB2) + (AW+1)'(unit_ff);
               default: raddr_full = (AW+1)'(OffB3);
            endcase
            j_in = '0; state_in = mpe_pkg::ST_RD;
         end
         mpe_pkg::ST_RD: begin
            // bias data arrives; load accumulator
            mac_ctl.clear = 1'b1;
            mac_init = 48'(signed'(w_rdata)) <<< 12;
            if (layer_ff == 2'd3) begin
               res_in = res_ff + (48'(signed'(w_rdata)) <<< 12);
               state_in = mpe_pkg::ST_OUT_MUL;
            end else begin
               state_in = mpe_pkg::ST_MAC;
            end
         end
         mpe_pkg::ST_MAC: begin
            if (j_ff < jmax) begin
               if (layer_ff == 2'd0) begin
                  // j indexes digits; dig[0] is digit j after rotation
                  raddr_full = (AW+1)'(unit_ff * Row0) + (AW+1)'(j_ff) +
                               ((dig[0] == 2'd1) ? (AW+1)'(len_eff) : '0);
                  d_sel_in = (dig[0] != 2'd2);
                  d_shift = 1'b1;
               end else begin
                  raddr_full = ((layer_ff == 2'd1) ? (AW+1)'(OffD1) : (AW+1)'(OffD2)) +
                               (AW+1)'(unit_ff * HIDDEN_WIDTH) + (AW+1)'(j_ff);
                  h_raddr = (layer_ff == 2'd1) ? HA'(j_ff) : HA'(HIDDEN_WIDTH) + HA'(j_ff);
               end
               rd_pend_in = 1'b1;
               j_in = j_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = mpe_pkg::ST_ACT;
               if (layer_ff == 2'd0) begin
                  // finish rotating the chain back to digit 0
                  dcnt_in = 4'(MAX_DIGITS) - len_eff;
               end
            end
         end
         mpe_pkg::ST_ACT: begin
            // wait for last product to land, realign digit chain
            if (layer_ff == 2'd0 && dcnt_ff != 4'd0) begin
               d_shift = 1'b1; dcnt_in = dcnt_ff - 4'd1;
            end else if (layer_ff == 2'd2) begin
               raddr_full = (AW+1)'(OffD3) + (AW+1)'(unit_ff);
               act_in = act16;
               state_in = mpe_pkg::ST_DONE;
            end else begin
               h_we = 1'b1;
               h_waddr = (layer_ff == 2'd0) ? HA'(unit_ff) : HA'(HIDDEN_WIDTH) + HA'(unit_ff);
               h_wdata = 32'(act16);
               if (unit_ff == HW'(HIDDEN_WIDTH - 1)) begin
                  unit_in = '0; layer_in = layer_ff + 2'd1;
               end else begin
                  unit_in = unit_ff + 1'b1;
               end
               state_in = mpe_pkg::ST_BIAS;
            end
         end
         mpe_pkg::ST_DONE: begin
            // layer 2 unit: res += act * dense3
            res_in = res_ff + 48'(act_ff * signed'(w_rdata));
            if (unit_ff == HW'(HIDDEN_WIDTH - 1)) begin
               unit_in = '0; layer_in = 2'd3;
            end else begin
               unit_in = unit_ff + 1'b1;
            end
            state_in = mpe_pkg::ST_BIAS;
         end
         mpe_pkg::ST_OUT_MUL: begin
            // times 6400 = 2^12 + 2^11 + 2^8
            mul_in = (64'(res_ff) <<< 12) + (64'(res_ff) <<< 11) + (64'(res_ff) <<< 8);
            state_in = mpe_pkg::ST_OUT_RND;
         end
         mpe_pkg::ST_OUT_RND: begin
            mag = mul_ff[63] ? -mul_ff : mul_ff;
            mag = (mag + (64'sd1 <<< 23)) >>> 24;
            if (mul_ff[63]) mag = -mag;
            if (mag > 64'sd8388607) score_in = 24'sh7fffff;
            else if (mag < -64'sd8388608) score_in = 24'sh800000;
            else score_in = mag[23:0];
            rsp_valid_in = 1'b1;
            state_in = mpe_pkg::ST_IDLE;
         end
         default: state_in = mpe_pkg::ST_IDLE;
      endcase
      w_raddr = raddr_full[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpe_pkg::ST_IDLE;
         len_ff <= mpe_pkg::LenReset;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         layer_ff <= '0; unit_ff <= '0; j_ff <= '0; dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         layer_ff <= layer_in; unit_ff <= unit_in; j_ff <= j_in; dcnt_ff <= dcnt_in;
         if (csr_valid && csr_ready) len_ff <= csr_pattern_length;
      end
      code_ff <= code_in; res_ff <= res_in; act_ff <= act_in;
      score_ff <= score_in; mul_ff <= mul_in; d_sel_ff <= d_sel_in;
   end

   assign csr_ready = (state_ff == mpe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = score_ff;
endmodule

FILE: design/mpe_checker.sv
// Port-level checker for the pattern evaluator, bound to the top level.
// Depends on mlp_pattern_evaluator_defines.svh.
`include "mlp_pattern_evaluator_defines.svh"
module mpe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_score
);
   `MPE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score), "rsp dropped")
   `MPE_ASSERT(a_load_no_rsp, req_valid && req_ready && !req_cmd && !rsp_valid |=> !rsp_valid, "load gave response")
   `MPE_ASSERT(a_eval_busy, req_valid && req_ready && req_cmd |=> !req_ready, "accepted during eval")
   `MPE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp after reset")
endmodule

bind mlp_pattern_evaluator mpe_checker u_mpe_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_cmd(req_cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_score(rsp_score));
